@@ design/hevm_pkg.sv @@
// shared types and constants for the hourly energy and voltage meter
`timescale 1ns / 1ps
`default_nettype none
package hevm_pkg;

    localparam int TIME_W   = 32;
    localparam int HOUR_W   = 5;
    localparam int POWER_W  = 20;
    localparam int VOLT_W   = 16;
    localparam int COUNT_W  = 32;
    localparam int OUT_W    = 48;
    localparam int PROD_W   = POWER_W + TIME_W;
    localparam int N_LANES  = 5;

    localparam logic [VOLT_W-1:0] VMIN_RESET = 16'd1000;

    typedef logic [POWER_W-1:0] t_power;
    typedef logic [TIME_W-1:0]  t_time;
    typedef logic [VOLT_W-1:0]  t_volt;

    // per-request flags decided at the front
    typedef struct packed {
        logic first;
        logic clear;
        logic volt_ok;
    } t_ctl;

    // pipeline controls handed to the lanes and the voltage unit
    typedef struct packed {
        logic en2;
        logic load3;
        logic first;
        logic clear;
    } t_stage_ctl;

endpackage
`default_nettype wire

@@ design/hevm_front.sv @@
// front stage: elapsed time, hour tracking and voltage qualification
`timescale 1ns / 1ps
`default_nettype none
module hevm_front import hevm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [TIME_W-1:0] i_now_ms,
    input  wire logic [HOUR_W-1:0] i_hour_of_day,
    input  wire t_power            i_power [N_LANES],
    input  wire logic [VOLT_W-1:0] i_line_voltage_cv,
    input  wire logic [VOLT_W-1:0] i_vmin,
    output t_time                  o_elapsed,
    output t_power                 o_power [N_LANES],
    output t_volt                  o_volt,
    output t_ctl                   o_ctl
);

    logic              r_hour_seen;
    logic [HOUR_W-1:0] r_stored_hour;
    t_time             r_last_time;
    t_time             r_elapsed;
    t_power            r_power [N_LANES];
    t_volt             r_volt;
    t_ctl              r_ctl;
    t_ctl              n_ctl;

    always_comb begin
        n_ctl.first   = !r_hour_seen;
        n_ctl.clear   = r_hour_seen && (i_hour_of_day != r_stored_hour);
        n_ctl.volt_ok = i_line_voltage_cv > i_vmin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour_seen   <= 1'b0;
            r_stored_hour <= '0;
            r_last_time   <= '0;
        end else if (i_accept) begin
            r_hour_seen   <= 1'b1;
            r_stored_hour <= i_hour_of_day;
            r_last_time   <= i_now_ms;
        end
    end

    // payload of stage one, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_elapsed <= i_now_ms - r_last_time;
            r_power   <= i_power;
            r_volt    <= i_line_voltage_cv;
            r_ctl     <= n_ctl;
        end
    end

    assign o_elapsed = r_elapsed;
    assign o_power   = r_power;
    assign o_volt    = r_volt;
    assign o_ctl     = r_ctl;

endmodule
`default_nettype wire

@@ design/hevm_lane.sv @@
// one energy lane: power times elapsed time into a saturating accumulator
`timescale 1ns / 1ps
`default_nettype none
module hevm_lane import hevm_pkg::*; #(
    parameter int ACC_WIDTH = 48
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire t_stage_ctl     i_ctl,
    input  wire t_power         i_power,
    input  wire t_time          i_elapsed,
    output logic [ACC_WIDTH-1:0] o_acc
);

    localparam int SUM_W = ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) + 1;

    logic [PROD_W-1:0]    r_prod;
    logic [ACC_WIDTH-1:0] r_acc;
    logic [ACC_WIDTH-1:0] n_acc;
    logic [ACC_WIDTH-1:0] w_base;
    logic [PROD_W-1:0]    w_add;
    logic [SUM_W-1:0]     w_sum;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en2) begin
            r_prod <= PROD_W'(i_power) * PROD_W'(i_elapsed);
        end
    end

    always_comb begin
        w_base = i_ctl.clear ? '0 : r_acc;
        w_add  = i_ctl.first ? '0 : r_prod;
        w_sum  = SUM_W'(w_base) + SUM_W'(w_add);
        // saturate when anything spills past the accumulator width
        n_acc  = (|w_sum[SUM_W-1:ACC_WIDTH]) ? '1 : w_sum[ACC_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.load3) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule
`default_nettype wire

@@ design/hevm_volt.sv @@
// voltage statistics: saturating sum and count, running min and max
`timescale 1ns / 1ps
`default_nettype none
module hevm_volt import hevm_pkg::*; #(
    parameter int ACC_WIDTH = 48
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_stage_ctl      i_ctl,
    input  wire t_volt           i_volt,
    input  wire logic            i_volt_ok,
    output logic [ACC_WIDTH-1:0] o_sum,
    output logic [COUNT_W-1:0]   o_count,
    output t_volt                o_min,
    output t_volt                o_max
);

    localparam int SUM_W = ACC_WIDTH + 1;

    t_volt                r_volt;
    logic                 r_volt_ok;
    logic [ACC_WIDTH-1:0] r_sum;
    logic [COUNT_W-1:0]   r_count;
    t_volt                r_min;
    t_volt                r_max;
    logic [ACC_WIDTH-1:0] n_sum;
    logic [COUNT_W-1:0]   n_count;
    t_volt                n_min;
    t_volt                n_max;
    logic [ACC_WIDTH-1:0] w_sum_base;
    logic [COUNT_W-1:0]   w_count_base;
    t_volt                w_min_base;
    t_volt                w_max_base;
    logic [SUM_W-1:0]     w_sum;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en2) begin
            r_volt    <= i_volt;
            r_volt_ok <= i_volt_ok;
        end
    end

    always_comb begin
        w_sum_base   = i_ctl.clear ? '0 : r_sum;
        w_count_base = i_ctl.clear ? '0 : r_count;
        w_min_base   = i_ctl.clear ? '1 : r_min;
        w_max_base   = i_ctl.clear ? '0 : r_max;
        w_sum        = SUM_W'(w_sum_base) + SUM_W'(r_volt);
        n_sum        = w_sum_base;
        n_count      = w_count_base;
        n_min        = w_min_base;
        n_max        = w_max_base;
        if (!i_ctl.first && r_volt_ok) begin
            n_sum   = w_sum[ACC_WIDTH] ? '1 : w_sum[ACC_WIDTH-1:0];
            n_count = (&w_count_base) ? w_count_base : w_count_base + 1'b1;
            n_min   = (r_volt < w_min_base) ? r_volt : w_min_base;
            n_max   = (r_volt > w_max_base) ? r_volt : w_max_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_min   <= '1;
            r_max   <= '0;
        end else if (i_ctl.load3) begin
            r_sum   <= n_sum;
            r_count <= n_count;
            r_min   <= n_min;
            r_max   <= n_max;
        end
    end

    assign o_sum   = r_sum;
    assign o_count = r_count;
    assign o_min   = r_min;
    assign o_max   = r_max;

endmodule
`default_nettype wire

@@ design/hourly_energy_voltage_meter.sv @@
// hourly energy and voltage meter, top level
// Usage: one request per sample on the input channel (i_valid, o_stall); it carries a
// ms timestamp, the hour, five powers in mW and the line voltage in centivolts.
// One result per request comes out on the output channel (o_valid, i_stall) with
// the five mW*ms energy accumulators and the voltage sum, count, min and max of
// the current hour, as they stand after that request.
// The front register loads on the accepting edge, then the product register,
// then the accumulators, which are updated together with o_valid rising.
// Throughput: one request per cycle while i_stall is low; the accumulators take one
// saturating add per request, which is the loop that sets the rate.
// The voltage floor is written on i_cfg_valid/o_cfg_ready, always ready;
// write it only while no request is in flight.
// Reset: accumulators clear, min reads 65535, floor reads 1000; the first
// request after reset only records hour and timestamp.
// When i_stall holds the result, up to three requests sit in the pipeline
// before o_stall rises; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none
module hourly_energy_voltage_meter import hevm_pkg::*; #(
    parameter int ACC_WIDTH = 48
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [TIME_W-1:0]  i_now_ms,
    input  wire logic [HOUR_W-1:0]  i_hour_of_day,
    input  wire logic [POWER_W-1:0] i_total_power_mw,
    input  wire logic [POWER_W-1:0] i_socket1_power_mw,
    input  wire logic [POWER_W-1:0] i_socket2_power_mw,
    input  wire logic [POWER_W-1:0] i_socket3_power_mw,
    input  wire logic [POWER_W-1:0] i_socket4_power_mw,
    input  wire logic [VOLT_W-1:0]  i_line_voltage_cv,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [VOLT_W-1:0]  i_cfg_data,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [OUT_W-1:0]        o_energy_total,
    output logic [OUT_W-1:0]        o_energy_socket1,
    output logic [OUT_W-1:0]        o_energy_socket2,
    output logic [OUT_W-1:0]        o_energy_socket3,
    output logic [OUT_W-1:0]        o_energy_socket4,
    output logic [OUT_W-1:0]        o_voltage_sum,
    output logic [COUNT_W-1:0]      o_voltage_count,
    output logic [VOLT_W-1:0]       o_voltage_min,
    output logic [VOLT_W-1:0]       o_voltage_max
);

    t_volt      r_vmin;
    logic       r_v1;
    logic       r_v2;
    logic       r_o_valid;
    t_ctl       r_ctl2;
    logic       w_accept;
    logic       w_en2;
    logic       w_load3;
    t_stage_ctl w_sctl;
    t_power     w_in_power [N_LANES];
    t_power     w_power1 [N_LANES];
    t_time      w_elapsed1;
    t_volt      w_volt1;
    t_ctl       w_ctl1;
    logic [ACC_WIDTH-1:0] w_acc [N_LANES];
    logic [OUT_W-1:0]     w_energy [N_LANES];
    logic [ACC_WIDTH-1:0] w_vsum;
    logic [OUT_W-1:0]     w_vsum_out;

    // pipeline moves forward wherever the next stage is free or draining
    assign w_load3  = r_v2 && (!r_o_valid || !i_stall);
    assign w_en2    = r_v1 && (!r_v2 || w_load3);
    assign o_stall  = r_v1 && !w_en2;
    assign w_accept = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_sctl.en2   = w_en2;
        w_sctl.load3 = w_load3;
        w_sctl.first = r_ctl2.first;
        w_sctl.clear = r_ctl2.clear;
    end

    assign w_in_power[0] = i_total_power_mw;
    assign w_in_power[1] = i_socket1_power_mw;
    assign w_in_power[2] = i_socket2_power_mw;
    assign w_in_power[3] = i_socket3_power_mw;
    assign w_in_power[4] = i_socket4_power_mw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vmin    <= VMIN_RESET;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_vmin <= i_cfg_data;
            end
            if (w_accept) begin
                r_v1 <= 1'b1;
            end else if (w_en2) begin
                r_v1 <= 1'b0;
            end
            if (w_en2) begin
                r_v2 <= 1'b1;
            end else if (w_load3) begin
                r_v2 <= 1'b0;
            end
            if (w_load3) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_ctl2 <= w_ctl1;
        end
    end

    hevm_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (w_accept),
        .i_now_ms          (i_now_ms),
        .i_hour_of_day     (i_hour_of_day),
        .i_power           (w_in_power),
        .i_line_voltage_cv (i_line_voltage_cv),
        .i_vmin            (r_vmin),
        .o_elapsed         (w_elapsed1),
        .o_power           (w_power1),
        .o_volt            (w_volt1),
        .o_ctl             (w_ctl1)
    );

    for (genvar g = 0; g < N_LANES; g++) begin : g_lane
        hevm_lane #(.ACC_WIDTH(ACC_WIDTH)) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_sctl),
            .i_power   (w_power1[g]),
            .i_elapsed (w_elapsed1),
            .o_acc     (w_acc[g])
        );
        if (ACC_WIDTH > OUT_W) begin : g_clamp
            assign w_energy[g] = (|w_acc[g][ACC_WIDTH-1:OUT_W]) ? '1 : w_acc[g][OUT_W-1:0];
        end else begin : g_ext
            assign w_energy[g] = OUT_W'(w_acc[g]);
        end
    end

    hevm_volt #(.ACC_WIDTH(ACC_WIDTH)) u_volt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_sctl),
        .i_volt    (w_volt1),
        .i_volt_ok (w_ctl1.volt_ok),
        .o_sum     (w_vsum),
        .o_count   (o_voltage_count),
        .o_min     (o_voltage_min),
        .o_max     (o_voltage_max)
    );

    if (ACC_WIDTH > OUT_W) begin : g_vclamp
        assign w_vsum_out = (|w_vsum[ACC_WIDTH-1:OUT_W]) ? '1 : w_vsum[OUT_W-1:0];
    end else begin : g_vext
        assign w_vsum_out = OUT_W'(w_vsum);
    end

    // accumulators only change on load, so they double as the output register
    assign o_valid          = r_o_valid;
    assign o_energy_total   = w_energy[0];
    assign o_energy_socket1 = w_energy[1];
    assign o_energy_socket2 = w_energy[2];
    assign o_energy_socket3 = w_energy[3];
    assign o_energy_socket4 = w_energy[4];
    assign o_voltage_sum    = w_vsum_out;

    a_load_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load3 |-> r_v2)
        else $error("accumulator load without a request in stage two");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_o_valid))
        else $error("input stalled while the pipeline has room");

    a_first_no_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> !(w_ctl1.first && w_ctl1.clear))
        else $error("first request flagged as hour change");

    a_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load3 && !r_ctl2.clear) |=> (o_voltage_count >= $past(o_voltage_count)))
        else $error("voltage count dropped without an hour change");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_voltage_count != '0) |-> (o_voltage_min <= o_voltage_max))
        else $error("voltage min above max with readings present");

endmodule
`default_nettype wire
